// ----- hdl/ufs_pkg.sv -----
package ufs_pkg;

   // Widths of the command and result words at the ports.
   localparam int CMD_W   = 2;
   localparam int OPND_W  = 10;
   localparam int ROOT_W  = 10;
   localparam int SIZE_W  = 11;

   localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAME  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SIZE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNITE = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_COMP_CHK,
      ST_WALK_END,
      ST_UNITE_KEEP,
      ST_UNITE_JOIN
   } state_type;

endpackage

// ----- hdl/ufs_ram.sv -----
module ufs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/union_find_by_size_unit.sv -----
// Disjoint-set engine, union by size with full path compression.
// A command word (find, same-set test, size, unite plus two element indices)
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the result word has been issued; one item is handled at a time.
// Each command gives exactly one result word, shown on the rsp_ ports for a
// single cycle with rsp_strobe high. The receiver cannot stall the block.
// Each parent link takes one read of the table, and every node rewritten by
// path compression is read once more and written. Find and size do one root
// lookup, the same-set test and unite do two, and a merge adds the two table
// writes. With compression, paths stay short. The result word shows in the
// first cycle that busy is low. When NUM_ELEMENTS is below 1024, the operands
// are first reduced modulo NUM_ELEMENTS in an extra state, ST_WRAP. After
// reset the table is swept to all singletons, one entry per cycle, and busy
// stays high until the sweep is done.
module union_find_by_size_unit
   import ufs_pkg::*;
#(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [OPND_W-1:0] req_operand_a,
   input  logic [OPND_W-1:0] req_operand_b,
   output logic              rsp_strobe,
   output logic [ROOT_W-1:0] rsp_root_index,
   output logic              rsp_answer_flag,
   output logic [SIZE_W-1:0] rsp_set_size
);

   localparam int  IDX_W     = $clog2(NUM_ELEMENTS);
   localparam int  SZ_W      = $clog2(NUM_ELEMENTS + 1);
   localparam int  ENTRY_W   = SZ_W + 1;
   localparam int  RECIP_SH  = 2 * OPND_W;
   localparam int  RECIP_M   = (1 << RECIP_SH) / NUM_ELEMENTS;
   localparam int  PROD_W    = OPND_W + RECIP_SH;
   localparam bit  NEED_WRAP = (NUM_ELEMENTS < (1 << OPND_W));
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);
   localparam logic [OPND_W-1:0] MOD_N    = OPND_W'(NUM_ELEMENTS);

   // A table entry is {root, value}: a root holds its set size, any other
   // element holds its parent index.
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [OPND_W-1:0]  rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic               phase_ff, phase_in;
   logic [IDX_W-1:0]   start_node_ff, start_node_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   root_ff, root_in;
   logic [SZ_W-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]   root_a_ff, root_a_in;
   logic [SZ_W-1:0]    size_a_ff, size_a_in;
   logic [IDX_W-1:0]   keep_ff, keep_in, join_ff, join_in;
   logic [SZ_W-1:0]    sum_ff, sum_in;
   logic [ROOT_W-1:0]  rsp_root_ff, rsp_root_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic [OPND_W-1:0]  rem_a_next, rem_b_next;
   logic               entry_root;
   logic [IDX_W-1:0]   entry_parent;
   logic [IDX_W-1:0]   b_idx;

   // The scaled reciprocal leaves the quotient at most one short, so one
   // conditional subtract finishes the remainder.
   function automatic logic [OPND_W-1:0] wrap_operand(input logic [OPND_W-1:0] x);
      logic [PROD_W-1:0] prod;
      logic [OPND_W-1:0] quot;
      logic [OPND_W-1:0] rem;
      prod = PROD_W'(x) * PROD_W'(RECIP_M);
      quot = prod[PROD_W-1:RECIP_SH];
      rem  = x - OPND_W'(quot * MOD_N);
      if (rem >= MOD_N) begin
         rem = rem - MOD_N;
      end
      return rem;
   endfunction

   ufs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_root   = rd_data[ENTRY_W-1];
   assign entry_parent = IDX_W'(rd_data[SZ_W-1:0]);
   assign b_idx        = IDX_W'(rem_b_ff);

   assign rem_a_next = wrap_operand(rem_a_ff);
   assign rem_b_next = wrap_operand(rem_b_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      cmd_in        = cmd_ff;
      rem_a_in      = rem_a_ff;
      rem_b_in      = rem_b_ff;
      phase_in      = phase_ff;
      start_node_in = start_node_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      size_in       = size_ff;
      root_a_in     = root_a_ff;
      size_a_in     = size_a_ff;
      keep_in       = keep_ff;
      join_in       = join_ff;
      sum_in        = sum_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_size_in   = rsp_size_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = {1'b0, SZ_W'(root_ff)};
      rd_addr       = cur_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b1, SZ_W'(1)};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in        = req_command;
               rem_a_in      = req_operand_a;
               rem_b_in      = req_operand_b;
               phase_in      = 1'b0;
               start_node_in = IDX_W'(req_operand_a);
               cur_in        = IDX_W'(req_operand_a);
               state_in      = NEED_WRAP ? ST_WRAP : ST_FIND_RD;
            end
         end
         ST_WRAP: begin
            rem_a_in      = rem_a_next;
            rem_b_in      = rem_b_next;
            start_node_in = IDX_W'(rem_a_next);
            cur_in        = IDX_W'(rem_a_next);
            state_in      = ST_FIND_RD;
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (entry_root) begin
               root_in = cur_ff;
               size_in = rd_data[SZ_W-1:0];
               if (start_node_ff == cur_ff) begin
                  state_in = ST_WALK_END;
               end else begin
                  cur_in   = start_node_ff;
                  rd_addr  = start_node_ff;
                  state_in = ST_COMP_CHK;
               end
            end else begin
               cur_in  = entry_parent;
               rd_addr = entry_parent;
            end
         end
         ST_COMP_CHK: begin
            // The node under cur is on the walked path and is not the root.
            if (entry_root) begin
               state_in = ST_WALK_END;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {1'b0, SZ_W'(root_ff)};
               if (entry_parent == root_ff) begin
                  state_in = ST_WALK_END;
               end else begin
                  cur_in  = entry_parent;
                  rd_addr = entry_parent;
               end
            end
         end
         ST_WALK_END: begin
            if (!phase_ff) begin
               root_a_in = root_ff;
               size_a_in = size_ff;
               if ((cmd_ff == CMD_FIND) || (cmd_ff == CMD_SIZE)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_root_in   = ROOT_W'(root_ff);
                  rsp_flag_in   = 1'b0;
                  rsp_size_in   = SIZE_W'(size_ff);
                  state_in      = ST_IDLE;
               end else begin
                  phase_in      = 1'b1;
                  start_node_in = b_idx;
                  cur_in        = b_idx;
                  state_in      = ST_FIND_RD;
               end
            end else if ((cmd_ff == CMD_SAME) || (root_a_ff == root_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_root_in   = ROOT_W'(root_a_ff);
               rsp_flag_in   = (cmd_ff == CMD_SAME) && (root_a_ff == root_ff);
               rsp_size_in   = SIZE_W'(size_a_ff);
               state_in      = ST_IDLE;
            end else begin
               // On equal sizes the first operand's root stays the root.
               if (size_a_ff < size_ff) begin
                  keep_in = root_ff;
                  join_in = root_a_ff;
               end else begin
                  keep_in = root_a_ff;
                  join_in = root_ff;
               end
               sum_in   = size_a_ff + size_ff;
               state_in = ST_UNITE_KEEP;
            end
         end
         ST_UNITE_KEEP: begin
            wr_en    = 1'b1;
            wr_addr  = keep_ff;
            wr_data  = {1'b1, sum_ff};
            state_in = ST_UNITE_JOIN;
         end
         ST_UNITE_JOIN: begin
            wr_en         = 1'b1;
            wr_addr       = join_ff;
            wr_data       = {1'b0, SZ_W'(keep_ff)};
            rsp_strobe_in = 1'b1;
            rsp_root_in   = ROOT_W'(keep_ff);
            rsp_flag_in   = 1'b1;
            rsp_size_in   = SIZE_W'(sum_ff);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rem_a_ff      <= rem_a_in;
      rem_b_ff      <= rem_b_in;
      phase_ff      <= phase_in;
      start_node_ff <= start_node_in;
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      size_ff       <= size_in;
      root_a_ff     <= root_a_in;
      size_a_ff     <= size_a_in;
      keep_ff       <= keep_in;
      join_ff       <= join_in;
      sum_ff        <= sum_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_root_index  = rsp_root_ff;
   assign rsp_answer_flag = rsp_flag_ff;
   assign rsp_set_size    = rsp_size_ff;

`ifndef ASSERT_OFF
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not make the block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("result word issued while a command is still in work");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIND_CHK) || (state_ff == ST_FIND_RD)) |-> !wr_en)
      else $error("table written during the root walk");

   a_compress_child: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_COMP_CHK)) |-> (!wr_data[ENTRY_W-1] && (wr_addr != root_ff)))
      else $error("path compression rewrote a root");
`endif

endmodule

// ----- sim/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufs_pkg::*;

   localparam int NUM_EL       = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 120;

   typedef logic signed [11:0] link_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              flag;
      logic [SIZE_W-1:0] set_size;
   } answer_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_command;
   logic [OPND_W-1:0] req_operand_a;
   logic [OPND_W-1:0] req_operand_b;
   logic              rsp_strobe;
   logic [ROOT_W-1:0] rsp_root_index;
   logic              rsp_answer_flag;
   logic [SIZE_W-1:0] rsp_set_size;

   // Shadow of the block's table: minus the set size at a root, else the parent.
   link_type   link_tab [NUM_EL];
   answer_type answer_q [$];
   int         mismatches  = 0;
   int         cycle_count = 0;
   int         calm_left   = 0;

   union_find_by_size_unit #(
      .NUM_ELEMENTS(NUM_EL)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_strobe     (rsp_strobe),
      .rsp_root_index (rsp_root_index),
      .rsp_answer_flag(rsp_answer_flag),
      .rsp_set_size   (rsp_set_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  answer_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Root lookup on the shadow table; every node on the walked path is
   // pointed straight at the root afterwards.
   function automatic logic [OPND_W-1:0] lookup_root(input logic [OPND_W-1:0] x);
      logic [OPND_W-1:0] r;
      logic [OPND_W-1:0] node;
      logic [OPND_W-1:0] nxt;
      int                steps;
      r     = x;
      steps = 0;
      while (link_tab[r] >= 0 && steps < NUM_EL) begin
         r = link_tab[r][OPND_W-1:0];
         steps++;
      end
      node  = x;
      steps = 0;
      while (node != r && link_tab[node] >= 0 && steps < NUM_EL) begin
         nxt            = link_tab[node][OPND_W-1:0];
         link_tab[node] = link_type'({2'b00, r});
         node           = nxt;
         steps++;
      end
      return r;
   endfunction

   function automatic answer_type predict_answer(input logic [CMD_W-1:0] cmd,
                                                 input logic [OPND_W-1:0] opa,
                                                 input logic [OPND_W-1:0] opb);
      answer_type        ans;
      logic [OPND_W-1:0] ra;
      logic [OPND_W-1:0] rb;
      logic [OPND_W-1:0] keep;
      logic [OPND_W-1:0] join_root;
      link_type          neg;
      ra       = lookup_root(OPND_W'(opa % NUM_EL));
      ans.flag = 1'b0;
      if (cmd == CMD_SAME) begin
         rb       = lookup_root(OPND_W'(opb % NUM_EL));
         ans.flag = (ra == rb);
      end else if (cmd == CMD_UNITE) begin
         rb = lookup_root(OPND_W'(opb % NUM_EL));
         if (ra != rb) begin
            keep      = ra;
            join_root = rb;
            // Equal sizes keep the first operand's root.
            if (link_tab[ra] > link_tab[rb]) begin
               keep      = rb;
               join_root = ra;
            end
            link_tab[keep]      = link_tab[keep] + link_tab[join_root];
            link_tab[join_root] = link_type'({2'b00, keep});
            ra       = keep;
            ans.flag = 1'b1;
         end
      end
      neg          = (link_tab[ra] < 0) ? -link_tab[ra] : link_type'(1);
      ans.root     = ra;
      ans.set_size = neg[SIZE_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin : check_words
      answer_type exp_w;
      if (!reset && rsp_strobe) begin
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result word: root %0d flag %0d size %0d",
                        rsp_root_index, rsp_answer_flag, rsp_set_size);
         end else begin
            exp_w = answer_q.pop_front();
            if (rsp_root_index !== exp_w.root || rsp_answer_flag !== exp_w.flag ||
                rsp_set_size !== exp_w.set_size) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: root %0d/%0d flag %0d/%0d size %0d/%0d (exp/act)",
                           exp_w.root, rsp_root_index, exp_w.flag, rsp_answer_flag,
                           exp_w.set_size, rsp_set_size);
            end
         end
      end
   end

   // Start is only lowered when a gap follows, so back-to-back words keep it high.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [OPND_W-1:0] opa,
                            input logic [OPND_W-1:0] opb);
      int gap;
      int pick;
      gap = 0;
      if (calm_left > 0) begin
         calm_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            calm_left = $urandom_range(15, 40);
         else if (pick < 40)
            gap = 0;
         else if (pick < 85)
            gap = $urandom_range(1, 3);
         else if (pick < 97)
            gap = $urandom_range(4, 12);
         else
            gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= opa;
      req_operand_b <= opb;
      do @(posedge clock); while (busy);
      answer_q.insert(answer_q.size(), predict_answer(cmd, opa, opb));
   endtask

   function automatic logic [CMD_W-1:0] random_command();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         return CMD_FIND;
      else if (pick < 45)
         return CMD_SAME;
      else if (pick < 60)
         return CMD_SIZE;
      return CMD_UNITE;
   endfunction

   task automatic test_directed();
      send_word(CMD_FIND, 10'd0, 10'd1023);
      send_word(CMD_FIND, 10'd1023, 10'd0);
      send_word(CMD_SIZE, 10'd0, 10'd0);
      send_word(CMD_SAME, 10'd0, 10'd1023);
      send_word(CMD_UNITE, 10'd0, 10'd1023);
      send_word(CMD_SAME, 10'd1023, 10'd0);
      send_word(CMD_SIZE, 10'd1023, 10'd682);
      // Unite of an element with itself and of two members of one set.
      send_word(CMD_UNITE, 10'd0, 10'd0);
      send_word(CMD_UNITE, 10'd1023, 10'd0);
      send_word(CMD_UNITE, 10'd5, 10'd6);
      send_word(CMD_UNITE, 10'd7, 10'd5);
      send_word(CMD_FIND, 10'd7, 10'd341);
      send_word(CMD_SIZE, 10'd6, 10'd1023);
      // Two pairs of equal size, then a lookup over a two-link path.
      send_word(CMD_UNITE, 10'd10, 10'd11);
      send_word(CMD_UNITE, 10'd12, 10'd13);
      send_word(CMD_UNITE, 10'd10, 10'd12);
      send_word(CMD_FIND, 10'd13, 10'd0);
      send_word(CMD_SIZE, 10'd13, 10'd0);
      send_word(CMD_UNITE, 10'd14, 10'd10);
      send_word(CMD_SIZE, 10'd14, 10'd5);
      send_word(CMD_SAME, 10'd682, 10'd341);
      send_word(CMD_UNITE, 10'd341, 10'd682);
      send_word(CMD_SAME, 10'd13, 10'd7);
   endtask

   // Pairwise merges of equal sets build trees of depth four, then random members
   // are probed so that long paths get compressed.
   task automatic test_merge_tree();
      int base;
      for (int round = 0; round < 3; round++) begin
         base = $urandom_range(2, 63) * 16;
         for (int step = 1; step < 16; step *= 2) begin
            for (int i = 0; i < 16; i += 2 * step) begin
               if ($urandom_range(0, 3) == 0)
                  send_word(CMD_UNITE, OPND_W'(base + i + step), OPND_W'(base + i));
               else
                  send_word(CMD_UNITE, OPND_W'(base + i), OPND_W'(base + i + step));
            end
         end
         for (int k = 0; k < 20; k++)
            send_word(k % 4 == 3 ? CMD_SIZE : (k % 2 ? CMD_SAME : CMD_FIND),
                      OPND_W'(base + $urandom_range(0, 15)),
                      OPND_W'(base + $urandom_range(0, 15)));
      end
   endtask

   task automatic test_random_ops();
      int                base;
      logic [OPND_W-1:0] opa;
      logic [OPND_W-1:0] opb;
      base = 0;
      for (int n = 0; n < 320; n++) begin
         if (n % 40 == 0)
            base = $urandom_range(0, NUM_EL - 64);
         if ($urandom_range(0, 4) == 0) begin
            opa = OPND_W'($urandom_range(0, NUM_EL - 1));
            opb = OPND_W'($urandom_range(0, NUM_EL - 1));
         end else begin
            opa = OPND_W'(base + $urandom_range(0, 63));
            opb = OPND_W'(base + $urandom_range(0, 63));
         end
         send_word(random_command(), opa, opb);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_command   <= CMD_FIND;
      req_operand_a <= '0;
      req_operand_b <= '0;
      for (int i = 0; i < NUM_EL; i++)
         link_tab[i] = -link_type'(1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_merge_tree();
      test_random_ops();

      start <= 1'b0;
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && answer_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/ufs_pkg.sv
hdl/ufs_ram.sv
hdl/union_find_by_size_unit.sv
sim/tb.sv
